// ===== hdl/dram_bank_request_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler files.
`ifndef DRAM_BANK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define DRAM_BANK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DBRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DBRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/dbrs_pkg.sv =====
// Package with types, constants and codes for the DRAM bank request scheduler.
package dbrs_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_BANKS   = 8;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = $clog2(NUM_BANKS);

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_HIT    = 2'd1;
  localparam logic [1:0] REG_MISS   = 2'd2;

  typedef struct packed {
    logic        request_present;
    logic [15:0] request_serial;
    logic [3:0]  request_thread;
    logic [2:0]  request_bank;
    logic [15:0] request_row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  bank_index;
    logic        issued;
    logic [15:0] issued_serial;
    logic [3:0]  issued_thread;
    logic [15:0] issued_row;
    logic        row_hit;
    logic        bank_busy;
    logic        request_accepted;
    logic        queue_full;
    logic        work_done;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] serial;
    logic [3:0]  thread;
    logic [2:0]  bank;
    logic [15:0] row;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_ISSUE, ST_APPEND, ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // latch tick, clear per-bank results
    logic scan_init; // begin scanning queue for current bank
    logic scan_step; // examine one entry
    logic issue;     // take chosen entry for current bank
    logic next_bank; // advance bank pointer
    logic append;    // append offered request and decrement countdowns
    logic emit_next; // advance output bank pointer
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;  // scan reached the end or found a final choice
    logic bank_ready; // current bank idle and queue not empty
    logic found;      // a candidate exists
    logic shifting;   // removal compaction in progress
    logic last_bank;  // bank pointer at the highest bank
    logic emit_last;  // output pointer at the highest bank
  } status_t;
endpackage

// ===== hdl/dbrs_datapath.sv =====
// Datapath of the scheduler: queue, bank state, selection scan and results.
module dbrs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dbrs_pkg::cmd_t      cmd,
  output dbrs_pkg::status_t   status,
  input  dbrs_pkg::in_item_t  item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output dbrs_pkg::out_item_t result
);
  import dbrs_pkg::*;
  `include "dram_bank_request_scheduler_core_defines.svh"

  logic       policy_mode;
  logic [7:0] row_hit_latency, row_miss_latency;
  entry_t     queue [QUEUE_DEPTH];
  logic [CW-1:0] queue_count;
  logic [7:0] countdown [NUM_BANKS];
  logic [15:0] open_row [NUM_BANKS];
  logic [NUM_BANKS-1:0] row_valid;
  in_item_t   tick;
  logic       accepted;
  logic [BW-1:0] bank, emit_bank;
  logic [CW-1:0] scan, cand_pos, shift_pos;
  logic       cand, cand_hit, shifting, picked;
  entry_t     taken [NUM_BANKS];
  logic [NUM_BANKS-1:0] issued, hit;

  logic same_bank, row_match, final_pick;
  entry_t cur;
  assign cur = queue[scan[QW-1:0]];
  assign same_bank = ({{(BW+1-3){1'b0}}, cur.bank} == {1'b0, bank});
  assign row_match = row_valid[bank] && (cur.row == open_row[bank]);
  assign final_pick = same_bank && (!policy_mode || row_match);

  // The scan ends once the queue is exhausted or a final choice has been registered.
  assign status.scan_done = (scan >= queue_count) || picked;
  assign status.bank_ready = (queue_count != '0) && (countdown[bank] == '0);
  assign status.found = cand;
  assign status.shifting = shifting;
  assign status.last_bank = (bank == BW'(NUM_BANKS - 1));
  assign status.emit_last = (emit_bank == BW'(NUM_BANKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 1'b0;
      row_hit_latency <= 8'd2;
      row_miss_latency <= 8'd6;
      queue_count <= '0;
      row_valid <= '0;
      shifting <= 1'b0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        countdown[i] <= '0;
        open_row[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POLICY: policy_mode <= cfg_data[0];
          REG_HIT:    row_hit_latency <= cfg_data;
          REG_MISS:   row_miss_latency <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        tick <= item;
        accepted <= item.request_present && (queue_count < CW'(QUEUE_DEPTH));
        bank <= '0;
        emit_bank <= '0;
        issued <= '0;
        hit <= '0;
      end
      if (cmd.scan_init) begin
        scan <= '0;
        cand <= 1'b0;
        picked <= 1'b0;
      end
      if (cmd.scan_step && !picked && scan < queue_count) begin
        if (same_bank && (!cand || final_pick)) begin
          cand <= 1'b1;
          cand_pos <= scan;
          cand_hit <= row_match;
        end
        if (same_bank && final_pick) picked <= 1'b1;
        else scan <= scan + 1'b1;
      end
      if (cmd.issue) begin
        taken[bank] <= queue[cand_pos[QW-1:0]];
        issued[bank] <= 1'b1;
        hit[bank] <= cand_hit;
        countdown[bank] <= cand_hit ? row_hit_latency : row_miss_latency;
        open_row[bank] <= queue[cand_pos[QW-1:0]].row;
        row_valid[bank] <= 1'b1;
        shift_pos <= cand_pos;
        shifting <= 1'b1;
      end
      if (shifting) begin
        // One compaction step per cycle closes the gap left by the removal.
        if (shift_pos + 1'b1 < queue_count) begin
          queue[shift_pos[QW-1:0]] <= queue[shift_pos[QW-1:0] + 1'b1];
          shift_pos <= shift_pos + 1'b1;
        end else begin
          queue_count <= queue_count - 1'b1;
          shifting <= 1'b0;
        end
      end
      if (cmd.next_bank) bank <= bank + 1'b1;
      if (cmd.append) begin
        if (accepted) begin
          queue[queue_count[QW-1:0]] <= entry_t'{tick.request_serial,
            tick.request_thread, tick.request_bank, tick.request_row};
          queue_count <= queue_count + 1'b1;
        end
        for (int i = 0; i < NUM_BANKS; i++)
          if (countdown[i] != '0) countdown[i] <= countdown[i] - 1'b1;
      end
      if (cmd.emit_next) emit_bank <= emit_bank + 1'b1;
    end
  end

  logic any_busy;
  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < NUM_BANKS; i++) any_busy |= (countdown[i] != '0);
  end

  always_comb begin
    result = '0;
    result.bank_index = 3'(emit_bank);
    result.issued = issued[emit_bank];
    if (issued[emit_bank]) begin
      result.issued_serial = taken[emit_bank].serial;
      result.issued_thread = taken[emit_bank].thread;
      result.issued_row = taken[emit_bank].row;
    end
    result.row_hit = hit[emit_bank];
    result.bank_busy = countdown[emit_bank] != '0;
    result.request_accepted = accepted;
    result.queue_full = queue_count >= CW'(QUEUE_DEPTH);
    result.work_done = (queue_count == '0) && !any_busy;
    result.last = status.emit_last;
  end

  `DBRS_ASSERT_IMP(a_count_range, 1'b1, queue_count <= CW'(QUEUE_DEPTH), "queue count overflow")
  `DBRS_ASSERT_IMP(a_issue_cand, cmd.issue, cand && !shifting, "issue without candidate")
  `DBRS_ASSERT_NXT(a_issue_busy, cmd.issue, row_valid[$past(bank)], "row not marked open")
endmodule

// ===== hdl/dbrs_ctrl.sv =====
// Controller state machine that sequences one tick through the banks.
module dbrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dbrs_pkg::status_t status,
  output dbrs_pkg::cmd_t    cmd
);
  import dbrs_pkg::*;
  `include "dram_bank_request_scheduler_core_defines.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status.shifting) begin
          if (!status.bank_ready) begin
            cmd.next_bank = !status.last_bank;
            state_next = status.last_bank ? ST_APPEND : ST_SCAN;
          end else begin
            cmd.scan_init = 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          cmd.scan_step = 1'b0;
          if (status.found) cmd.issue = 1'b1;
          cmd.next_bank = !status.last_bank;
          state_next = status.last_bank ? ST_APPEND : ST_SCAN;
        end
      end
      ST_APPEND: begin
        if (!status.shifting) begin
          cmd.append = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = !status.emit_last;
          if (status.emit_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `DBRS_ASSERT_IMP(a_ready_idle, in_ready, state == ST_IDLE, "ready outside idle")
  `DBRS_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.issue, cmd.append, cmd.start}),
                   "conflicting commands")
  `DBRS_ASSERT_NXT(a_emit_hold, out_valid && !out_ready, out_valid, "result withdrawn")
endmodule

// ===== hdl/dram_bank_request_scheduler_core.sv =====
// Top level of the DRAM bank request scheduler.
// One input transfer is one DRAM tick, optionally carrying a request; it yields
// NUM_BANKS result transfers in bank order, the last flagged by last. Banks are
// served one after another by a shared queue scan: a busy bank is skipped, an
// idle bank has the queue examined entry by entry, and each issue is followed
// by moving the later entries down to close the gap before work goes on. The
// offered request is appended after the last bank has been served, and then
// the results are emitted.
// One tick is handled at a time. Configuration writes are accepted at any time
// but should only be made between ticks.
module dram_bank_request_scheduler_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dbrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dbrs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import dbrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  dbrs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd
  );

  dbrs_datapath u_dp (
    .clk, .rst, .cmd, .status, .item(in_data),
    .cfg_we(cfg_valid), .cfg_index, .cfg_data, .result(out_data)
  );
endmodule
